FILE: rtl/vector_normalize_unit_macros.svh
// Assertion macros shared by the vector normalize unit.
// Depends on nothing; included by files that assert.
`ifndef VECTOR_NORMALIZE_UNIT_MACROS_SVH
`define VECTOR_NORMALIZE_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define VNU_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define VNU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/vnorm_pkg.sv
// Package for the vector normalize unit: sizes and beat payload types.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package vnorm_pkg;
    localparam int COMPONENT_BITS = 16;
    localparam int FRACTION_BITS  = 14;
    localparam int UNIT_BITS      = FRACTION_BITS + 2;

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] vec_z;
        logic signed [COMPONENT_BITS-1:0] vec_y;
        logic signed [COMPONENT_BITS-1:0] vec_x;
    } vec_in_t;

    typedef struct packed {
        logic                        zero_length;
        logic signed [UNIT_BITS-1:0] unit_z;
        logic signed [UNIT_BITS-1:0] unit_y;
        logic signed [UNIT_BITS-1:0] unit_x;
    } vec_out_t;
endpackage
`default_nettype wire

FILE: rtl/vector_normalize_unit.sv
// Vector normalize unit: pipelined magnitude, square root and three dividers.
// Depends on vnorm_pkg and vector_normalize_unit_macros.svh.
//
// Usage:
//  - s_ channel carries one vector (x, y, z) per beat; m_ channel one unit
//    vector in signed Q1.FRACTION_BITS plus a zero_length flag per beat.
//  - Throughput: one vector per cycle, with no gaps, while the receiver takes beats.
//  - Pipeline from input beat to result: three front stages, the restoring
//    square root with one stage per root bit, the dividers with one stage
//    per quotient bit, then the output register.
//  - One global enable moves the whole pipeline: a stage advances when the
//    output register is empty or being taken, so a stalled receiver freezes
//    every stage and nothing is lost or repeated. s_ready follows m_ready
//    whenever the output holds a beat.
//  - Reset (aresetn low, synchronous) clears all valid bits; payload
//    registers are not reset.
//  - A zero vector's division result is discarded: components are forced to 0 and
//    zero_length is set.
`timescale 1ns / 1ps
`default_nettype none
`include "vector_normalize_unit_macros.svh"
module vector_normalize_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire vnorm_pkg::vec_in_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output vnorm_pkg::vec_out_t     m_data
);
    localparam int COMPONENT_BITS = vnorm_pkg::COMPONENT_BITS;
    localparam int FRACTION_BITS  = vnorm_pkg::FRACTION_BITS;
    localparam int CB    = COMPONENT_BITS;
    localparam int MB    = CB;                 // magnitude bits (holds 2^(CB-1))
    localparam int SB    = 2 * CB + 2;         // sum of three squares
    localparam int RB    = CB + 1;             // root bits
    localparam int RSTEP = SB / 2;             // root stages
    localparam int UB    = FRACTION_BITS + 2;
    localparam int NB    = MB + FRACTION_BITS; // dividend bits
    localparam int QB    = FRACTION_BITS + 2;  // quotient bits kept
    localparam int DSTEP = QB;

    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---------------- stage 1: magnitudes and signs
    logic            v1_reg;
    logic [MB-1:0]   mag1_reg [3];
    logic [2:0]      neg1_reg;
    logic [CB-1:0]   comp [3];
    assign comp[0] = s_data.vec_x;
    assign comp[1] = s_data.vec_y;
    assign comp[2] = s_data.vec_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                neg1_reg[i] <= comp[i][CB-1];
                mag1_reg[i] <= comp[i][CB-1] ? (~comp[i] + 1'b1) : comp[i];
            end
        end
    end

    // ---------------- stage 2: squares
    logic            v2_reg;
    logic [2*MB-1:0] sq2_reg [3];
    logic [MB-1:0]   mag2_reg [3];
    logic [2:0]      neg2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                sq2_reg[i]  <= mag1_reg[i] * mag1_reg[i];
                mag2_reg[i] <= mag1_reg[i];
            end
            neg2_reg <= neg1_reg;
        end
    end

    // ---------------- stage 3: sum of squares
    logic          v3_reg;
    logic [SB-1:0] sum3_reg;
    logic [MB-1:0] mag3_reg [3];
    logic [2:0]    neg3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            sum3_reg <= SB'(sq2_reg[0]) + SB'(sq2_reg[1]) + SB'(sq2_reg[2]);
            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
        end
    end

    // ---------------- square root: one root bit per stage
    logic          rv_reg   [RSTEP+1];
    logic [SB-1:0] rrem_reg [RSTEP+1];
    logic [RB-1:0] rroot_reg[RSTEP+1];
    logic [MB-1:0] rmag_reg [RSTEP+1][3];
    logic [2:0]    rneg_reg [RSTEP+1];
    logic          rzero_reg[RSTEP+1];

    always_comb begin
        rv_reg[0]    = v3_reg;
        rrem_reg[0]  = sum3_reg;
        rroot_reg[0] = '0;
        rmag_reg[0]  = mag3_reg;
        rneg_reg[0]  = neg3_reg;
        rzero_reg[0] = (sum3_reg == '0);
    end

    for (genvar k = 0; k < RSTEP; k++) begin : g_root
        localparam int SH = 2 * (RSTEP - 1 - k);
        logic [SB+1:0] trial;
        logic [SB+1:0] rem_w;
        always_comb begin
            trial = ((SB+2)'(rroot_reg[k]) << (SH + 2)) | ((SB+2)'(1) << SH);
            rem_w = (SB+2)'(rrem_reg[k]);
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rv_reg[k+1] <= 1'b0;
            end else if (adv) begin
                rv_reg[k+1] <= rv_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (rem_w >= trial) begin
                    rrem_reg[k+1]  <= SB'(rem_w - trial);
                    rroot_reg[k+1] <= {rroot_reg[k][RB-2:0], 1'b1};
                end else begin
                    rrem_reg[k+1]  <= rrem_reg[k];
                    rroot_reg[k+1] <= {rroot_reg[k][RB-2:0], 1'b0};
                end
                rmag_reg[k+1]  <= rmag_reg[k];
                rneg_reg[k+1]  <= rneg_reg[k];
                rzero_reg[k+1] <= rzero_reg[k];
            end
        end
    end

    // ---------------- three restoring dividers, one quotient bit per stage
    logic          dv_reg   [DSTEP+1];
    logic [NB-1:0] drem_reg [DSTEP+1][3];
    logic [QB-1:0] dq_reg   [DSTEP+1][3];
    logic [RB-1:0] dlen_reg [DSTEP+1];
    logic [2:0]    dneg_reg [DSTEP+1];
    logic          dzero_reg[DSTEP+1];
    logic [RB-1:0] len_safe;

    // A zero length would divide by zero; use one to keep the datapath defined.
    assign len_safe = rzero_reg[RSTEP] ? RB'(1) : rroot_reg[RSTEP];

    always_comb begin
        dv_reg[0]    = rv_reg[RSTEP];
        dlen_reg[0]  = len_safe;
        dneg_reg[0]  = rneg_reg[RSTEP];
        dzero_reg[0] = rzero_reg[RSTEP];
        for (int i = 0; i < 3; i++) begin
            drem_reg[0][i] = {rmag_reg[RSTEP][i], {FRACTION_BITS{1'b0}}};
            dq_reg[0][i]   = '0;
        end
    end

    // Quotient never exceeds 2^FRACTION_BITS, so only QB bits are produced.
    for (genvar k = 0; k < DSTEP; k++) begin : g_div
        localparam int SH = DSTEP - 1 - k;
        logic [NB+RB-1:0] dsh;
        assign dsh = (NB+RB)'(dlen_reg[k]) << SH;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k+1] <= 1'b0;
            end else if (adv) begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int i = 0; i < 3; i++) begin
                    if ((NB+RB)'(drem_reg[k][i]) >= dsh) begin
                        drem_reg[k+1][i] <= NB'((NB+RB)'(drem_reg[k][i]) - dsh);
                        dq_reg[k+1][i]   <= {dq_reg[k][i][QB-2:0], 1'b1};
                    end else begin
                        drem_reg[k+1][i] <= drem_reg[k][i];
                        dq_reg[k+1][i]   <= {dq_reg[k][i][QB-2:0], 1'b0};
                    end
                end
                dlen_reg[k+1]  <= dlen_reg[k];
                dneg_reg[k+1]  <= dneg_reg[k];
                dzero_reg[k+1] <= dzero_reg[k];
            end
        end
    end

    // ---------------- output register: apply signs, force zero case
    logic [UB-1:0] uval [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dzero_reg[DSTEP]) begin
                uval[i] = '0;
            end else if (dneg_reg[DSTEP][i]) begin
                uval[i] = UB'(~dq_reg[DSTEP][i] + 1'b1);
            end else begin
                uval[i] = UB'(dq_reg[DSTEP][i]);
            end
        end
    end

    logic m_valid_reg;
    vnorm_pkg::vec_out_t m_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_reg[DSTEP];
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg.unit_x      <= uval[0];
            m_data_reg.unit_y      <= uval[1];
            m_data_reg.unit_z      <= uval[2];
            m_data_reg.zero_length <= dzero_reg[DSTEP];
        end
    end
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- checks
    `VNU_ASSERT_NEXT(a_hold_stall, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `VNU_ASSERT_IMPL(a_zero_out, aclk, aresetn, m_valid && m_data.zero_length, m_data.unit_x == '0 && m_data.unit_y == '0 && m_data.unit_z == '0)
    `VNU_ASSERT_IMPL(a_ready_flow, aclk, aresetn, !m_valid, s_ready)
endmodule
`default_nettype wire
